[design/ntds_pkg.sv]
package ntds_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DIST_WIDTH  = 32;
    localparam int VAL_W       = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CMP_W       = (DIST_WIDTH > VAL_W) ? DIST_WIDTH : VAL_W;
    localparam int KC_W        = (DIST_WIDTH > DEPTH_W) ? DIST_WIDTH : DEPTH_W;

    typedef logic [DIST_WIDTH-1:0] t_dist;
    typedef logic [VAL_W-1:0]      t_val;
    typedef logic [DEPTH_W-1:0]    t_depth;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CMP_W-1:0]      t_cmp;
    typedef logic [CMP_W:0]        t_wide;
    typedef logic [KC_W-1:0]       t_kc;

    typedef enum logic [2:0] {
        MODE_START       = 3'd0,
        MODE_SCAN_CHAIN  = 3'd1,
        MODE_STACK_SNARL = 3'd2,
        MODE_SCAN_SNARL  = 3'd3,
        MODE_SKIP_CHAIN  = 3'd4
    } t_mode;

    localparam logic [2:0] K_SEED        = 3'd0;
    localparam logic [2:0] K_SNARL_START = 3'd1;
    localparam logic [2:0] K_SNARL_END   = 3'd2;
    localparam logic [2:0] K_CHAIN_START = 3'd3;
    localparam logic [2:0] K_CHAIN_END   = 3'd4;
    localparam logic [2:0] K_EDGE        = 3'd5;

    localparam logic [1:0] ST_SEED     = 2'd0;
    localparam logic [1:0] ST_HALT     = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_DECODE,
        SEQ_EDGE,
        SEQ_SE_P,
        SEQ_SE_C,
        SEQ_PUSH,
        SEQ_CE_K,
        SEQ_REV_A,
        SEQ_REV_B,
        SEQ_REV_C,
        SEQ_ENTER_RD,
        SEQ_ENTER,
        SEQ_SKIP,
        SEQ_TOP_RD,
        SEQ_EMIT
    } t_seq;

    // saturating add, clip the addend to the distance maximum first
    function automatic t_dist sat_add(input t_dist a, input t_val b);
        t_wide dmax;
        t_wide ax;
        t_wide bx;
        t_wide s;
        dmax = t_wide'(t_dist'('1));
        ax   = t_wide'(a);
        bx   = t_wide'(b);
        if (bx > dmax) bx = dmax;
        s = ax + bx;
        if (s > dmax) return t_dist'('1);
        return t_dist'(s);
    endfunction

    function automatic logic gt_limit(input t_dist a, input t_val lim);
        return t_cmp'(a) > t_cmp'(lim);
    endfunction

endpackage

[design/ntds_ram.sv]
module ntds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/nested_tree_distance_scanner.sv]
// Backward scanner over a serialized snarl/chain tree. Each input word is one
// token (kind and value); the block keeps a stack of running distances in a
// single-port-read, single-port-write RAM with a registered read port and
// walks it with a small sequencer, so one token is handled at a time. A seed
// met while scanning a chain, or a halt, a disallowed token or a stack
// overflow, produces one output word; halt, error and overflow then freeze the
// scanner until a token with first set restarts it. Tokens that only change
// the mode or push need no stack read; tokens that read and rewrite the top
// of the stack pass through read states, and a produced word adds a top read
// and an output load. A chain end in stack-snarl mode drops the count and the
// snarl slot, then reverses the top k entries in place one swapped pair at a
// time; the single RAM read port serializes all of these steps.
// Sums saturate at the distance maximum. The distance limit may be rewritten
// at any time the block is idle; it takes effect for the next token. The
// stack RAM needs no clearing: only entries below the current depth are read.
module nested_tree_distance_scanner (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_distance_limit_we,
    input  logic [31:0]          i_distance_limit,
    // token input
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_first,
    input  logic [2:0]           i_kind,
    input  logic [31:0]          i_token_value,
    // result output
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [31:0]          o_seed_index,
    output logic [31:0]          o_distance
);

    import ntds_pkg::*;

    // control state
    t_seq   r_seq,       n_seq;
    t_mode  r_mode,      n_mode;
    t_depth r_depth,     n_depth;
    logic   r_stopped,   n_stopped;
    logic   r_out_valid, n_out_valid;
    t_val   r_limit;

    // token and scratch payload
    logic [2:0] r_kind,   n_kind;
    t_val       r_val,    n_val;
    logic [1:0] r_status, n_status;
    t_dist      r_a,      n_a;
    t_depth     r_lo,     n_lo;
    t_depth     r_hi,     n_hi;
    logic [1:0] r_out_status, n_out_status;
    t_val       r_out_seed,   n_out_seed;
    t_val       r_out_dist,   n_out_dist;

    // stack RAM ports
    logic   ram_we;
    t_addr  ram_waddr;
    t_dist  ram_wdata;
    t_addr  ram_raddr;
    t_dist  ram_rdata;

    // decode helpers
    logic   dec_push;
    t_mode  dec_push_mode;
    logic   dec_err;
    t_depth dm1;
    t_depth dm2;
    t_addr  a_top;
    t_addr  a_sec;
    t_addr  a_push;
    logic   full;
    t_dist  sum_top;
    t_depth hi_m1;
    t_depth lo_p1;

    ntds_ram #(
        .WIDTH (DIST_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign dm1     = r_depth - t_depth'(1);
    assign dm2     = r_depth - t_depth'(2);
    assign a_top   = dm1[ADDR_W-1:0];
    assign a_sec   = dm2[ADDR_W-1:0];
    assign a_push  = r_depth[ADDR_W-1:0];
    assign full    = (r_depth == t_depth'(STACK_DEPTH));
    assign sum_top = sat_add(ram_rdata, r_val);
    assign hi_m1   = r_hi - t_depth'(1);
    assign lo_p1   = r_lo + t_depth'(1);

    assign o_ready      = (r_seq == SEQ_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_seed_index = r_out_seed;
    assign o_distance   = r_out_dist;

    always_comb begin
        n_seq        = r_seq;
        n_mode       = r_mode;
        n_depth      = r_depth;
        n_stopped    = r_stopped;
        n_kind       = r_kind;
        n_val        = r_val;
        n_status     = r_status;
        n_a          = r_a;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_out_valid  = r_out_valid & ~i_ready;
        n_out_status = r_out_status;
        n_out_seed   = r_out_seed;
        n_out_dist   = r_out_dist;
        ram_we       = 1'b0;
        ram_waddr    = a_top;
        ram_wdata    = '0;
        ram_raddr    = a_top;
        dec_push      = 1'b0;
        dec_push_mode = r_mode;
        dec_err       = 1'b0;

        unique case (r_seq)
            SEQ_IDLE: begin
                if (i_valid) begin
                    n_kind = i_kind;
                    n_val  = i_token_value;
                    // first token restarts the scan before it is handled
                    if (i_first) begin
                        n_mode    = MODE_START;
                        n_depth   = '0;
                        n_stopped = 1'b0;
                    end
                    n_seq = SEQ_DECODE;
                end
            end

            SEQ_DECODE: begin
                n_seq = SEQ_IDLE;
                if (!r_stopped) begin
                    unique case (r_mode)
                        MODE_START: begin
                            if (r_kind == K_SEED) begin
                                dec_push      = 1'b1;
                                dec_push_mode = MODE_SCAN_CHAIN;
                            end else begin
                                dec_err = 1'b1;
                            end
                        end
                        MODE_SCAN_CHAIN: begin
                            unique case (r_kind)
                                K_SEED: begin
                                    if (r_depth == '0) begin
                                        dec_err = 1'b1;
                                    end else begin
                                        n_status = ST_SEED;
                                        n_seq    = SEQ_TOP_RD;
                                    end
                                end
                                K_SNARL_END: begin
                                    dec_push      = 1'b1;
                                    dec_push_mode = MODE_STACK_SNARL;
                                end
                                K_CHAIN_START: begin
                                    if (r_depth == t_depth'(1)) begin
                                        dec_push      = 1'b1;
                                        dec_push_mode = MODE_STACK_SNARL;
                                    end else if (r_depth == '0) begin
                                        dec_err = 1'b1;
                                    end else begin
                                        n_depth = dm1;
                                        n_mode  = MODE_SCAN_SNARL;
                                    end
                                end
                                K_EDGE: begin
                                    if (r_depth == '0) begin
                                        dec_err = 1'b1;
                                    end else begin
                                        ram_raddr = a_top;
                                        n_seq     = SEQ_EDGE;
                                    end
                                end
                                default: dec_err = 1'b1;
                            endcase
                        end
                        MODE_STACK_SNARL: begin
                            unique case (r_kind)
                                K_EDGE: begin
                                    if (r_depth < t_depth'(2)) begin
                                        dec_err = 1'b1;
                                    end else if (full) begin
                                        n_status  = ST_OVERFLOW;
                                        n_stopped = 1'b1;
                                        n_seq     = SEQ_TOP_RD;
                                    end else begin
                                        ram_raddr = a_sec;
                                        n_seq     = SEQ_SE_P;
                                    end
                                end
                                K_CHAIN_END: begin
                                    if (r_depth < t_depth'(3)) begin
                                        dec_err = 1'b1;
                                    end else begin
                                        ram_raddr = a_top;
                                        n_seq     = SEQ_CE_K;
                                    end
                                end
                                default: dec_err = 1'b1;
                            endcase
                        end
                        MODE_SCAN_SNARL: begin
                            unique case (r_kind)
                                K_SNARL_START: n_mode = MODE_SCAN_CHAIN;
                                K_CHAIN_END: begin
                                    if (r_depth == '0) begin
                                        dec_err = 1'b1;
                                    end else begin
                                        ram_raddr = a_top;
                                        n_seq     = SEQ_ENTER;
                                    end
                                end
                                K_EDGE: n_seq = SEQ_IDLE;
                                default: dec_err = 1'b1;
                            endcase
                        end
                        MODE_SKIP_CHAIN: begin
                            unique case (r_kind)
                                K_SEED, K_CHAIN_END, K_EDGE: n_seq = SEQ_IDLE;
                                K_SNARL_START, K_SNARL_END, K_CHAIN_START: begin
                                    if (r_depth == '0) begin
                                        dec_err = 1'b1;
                                    end else begin
                                        ram_raddr = a_top;
                                        n_seq     = SEQ_SKIP;
                                    end
                                end
                                default: dec_err = 1'b1;
                            endcase
                        end
                        default: dec_err = 1'b1;
                    endcase

                    if (dec_push) begin
                        if (full) begin
                            n_status  = ST_OVERFLOW;
                            n_stopped = 1'b1;
                            n_seq     = SEQ_TOP_RD;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = a_push;
                            ram_wdata = '0;
                            n_depth   = r_depth + t_depth'(1);
                            n_mode    = dec_push_mode;
                        end
                    end
                    if (dec_err) begin
                        n_status  = ST_ERROR;
                        n_stopped = 1'b1;
                        n_seq     = SEQ_TOP_RD;
                    end
                end
            end

            // add the edge to the top; over the limit halts the outer chain
            // or starts skipping an inner one
            SEQ_EDGE: begin
                ram_we    = 1'b1;
                ram_waddr = a_top;
                ram_wdata = sum_top;
                n_seq     = SEQ_IDLE;
                if (gt_limit(sum_top, r_limit)) begin
                    if (r_depth == t_depth'(1)) begin
                        n_status  = ST_HALT;
                        n_stopped = 1'b1;
                        n_seq     = SEQ_TOP_RD;
                    end else begin
                        n_mode = MODE_SKIP_CHAIN;
                        if (full) begin
                            n_status  = ST_OVERFLOW;
                            n_stopped = 1'b1;
                            n_seq     = SEQ_TOP_RD;
                        end else begin
                            n_a   = '0;
                            n_seq = SEQ_PUSH;
                        end
                    end
                end
            end

            // stacked snarl edge: second gets p+edge, top gets p, push count+1
            SEQ_SE_P: begin
                n_a       = ram_rdata;
                ram_we    = 1'b1;
                ram_waddr = a_sec;
                ram_wdata = sum_top;
                ram_raddr = a_top;
                n_seq     = SEQ_SE_C;
            end

            SEQ_SE_C: begin
                ram_we    = 1'b1;
                ram_waddr = a_top;
                ram_wdata = r_a;
                n_a       = ram_rdata + t_dist'(1);
                n_seq     = SEQ_PUSH;
            end

            SEQ_PUSH: begin
                ram_we    = 1'b1;
                ram_waddr = a_push;
                ram_wdata = r_a;
                n_depth   = r_depth + t_depth'(1);
                n_seq     = SEQ_IDLE;
            end

            // top holds the edge count k; drop it and the snarl slot, then
            // reverse the k distances below
            SEQ_CE_K: begin
                if (t_kc'(ram_rdata) > t_kc'(dm2)) begin
                    n_status  = ST_ERROR;
                    n_stopped = 1'b1;
                    n_seq     = SEQ_TOP_RD;
                end else begin
                    n_depth = dm2;
                    n_lo    = dm2 - t_depth'(ram_rdata);
                    n_hi    = dm2;
                    if ((n_lo + t_depth'(1)) < n_hi) begin
                        ram_raddr = n_lo[ADDR_W-1:0];
                        n_seq     = SEQ_REV_A;
                    end else begin
                        n_seq = SEQ_ENTER_RD;
                    end
                end
            end

            SEQ_REV_A: begin
                n_a       = ram_rdata;
                ram_raddr = hi_m1[ADDR_W-1:0];
                n_seq     = SEQ_REV_B;
            end

            SEQ_REV_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                n_seq     = SEQ_REV_C;
            end

            SEQ_REV_C: begin
                ram_we    = 1'b1;
                ram_waddr = hi_m1[ADDR_W-1:0];
                ram_wdata = r_a;
                n_lo      = lo_p1;
                n_hi      = hi_m1;
                if ((r_lo + t_depth'(3)) < r_hi) begin
                    ram_raddr = lo_p1[ADDR_W-1:0];
                    n_seq     = SEQ_REV_A;
                end else begin
                    n_seq = SEQ_ENTER_RD;
                end
            end

            SEQ_ENTER_RD: begin
                ram_raddr = a_top;
                n_seq     = SEQ_ENTER;
            end

            // enter the chain on top, or skip it when already too far
            SEQ_ENTER: begin
                n_seq = SEQ_IDLE;
                if (gt_limit(ram_rdata, r_limit)) begin
                    n_mode = MODE_SKIP_CHAIN;
                    if (full) begin
                        n_status  = ST_OVERFLOW;
                        n_stopped = 1'b1;
                        n_seq     = SEQ_TOP_RD;
                    end else begin
                        n_a   = '0;
                        n_seq = SEQ_PUSH;
                    end
                end else begin
                    n_mode = MODE_SCAN_CHAIN;
                end
            end

            // top is the snarl nesting level inside a skipped chain
            SEQ_SKIP: begin
                n_seq = SEQ_IDLE;
                priority case (r_kind)
                    K_SNARL_START: begin
                        ram_we    = 1'b1;
                        ram_waddr = a_top;
                        ram_wdata = ram_rdata - t_dist'(1);
                    end
                    K_SNARL_END: begin
                        ram_we    = 1'b1;
                        ram_waddr = a_top;
                        ram_wdata = ram_rdata + t_dist'(1);
                    end
                    default: begin
                        if (ram_rdata == '0) begin
                            if (r_depth < t_depth'(3)) begin
                                n_status  = ST_ERROR;
                                n_stopped = 1'b1;
                                n_seq     = SEQ_TOP_RD;
                            end else begin
                                n_depth = dm2;
                                n_mode  = MODE_SCAN_SNARL;
                            end
                        end
                    end
                endcase
            end

            SEQ_TOP_RD: begin
                ram_raddr = a_top;
                n_seq     = SEQ_EMIT;
            end

            // hold until the output register is free; the read stays on top
            SEQ_EMIT: begin
                ram_raddr = a_top;
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_seed   = (r_status == ST_SEED) ? r_val : '0;
                    n_out_dist   = (r_depth != '0) ? t_val'(ram_rdata) : '0;
                    n_seq        = SEQ_IDLE;
                end
            end

            default: n_seq = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SEQ_IDLE;
            r_mode      <= MODE_START;
            r_depth     <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= '1;
        end else begin
            r_seq       <= n_seq;
            r_mode      <= n_mode;
            r_depth     <= n_depth;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
            if (i_distance_limit_we) begin
                r_limit <= i_distance_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_val        <= n_val;
        r_status     <= n_status;
        r_a          <= n_a;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_out_status <= n_out_status;
        r_out_seed   <= n_out_seed;
        r_out_dist   <= n_out_dist;
    end

endmodule

[test/tb_nested_tree_distance_scanner.sv]
`timescale 1ns / 100ps

import ntds_pkg::*;

// Tracks the scanner state token by token and keeps the words it must emit.
class tree_scan_model;
    typedef struct packed {
        logic [1:0] status;
        t_val       seed;
        t_dist      dist_val;
    } scan_word_t;

    t_mode       mode;
    t_dist       dists[STACK_DEPTH];
    int unsigned depth;
    bit          halted;
    t_dist       limit;
    scan_word_t  pending_words[$];
    int unsigned mismatches;
    bit          emit;
    logic [1:0]  code;

    function new();
        mode       = MODE_START;
        depth      = 0;
        halted     = 1'b0;
        limit      = '1;
        mismatches = 0;
    endfunction

    function void raise(logic [1:0] s);
        emit = 1'b1;
        code = s;
    endfunction

    function t_dist add_sat(t_dist a, t_val b);
        logic [DIST_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_WIDTH] ? '1 : s[DIST_WIDTH-1:0];
    endfunction

    // open a new level at distance zero; flag overflow when full
    function bit push_zero();
        if (depth >= STACK_DEPTH) begin
            raise(ST_OVERFLOW);
            return 1'b0;
        end
        dists[depth] = '0;
        depth++;
        return 1'b1;
    endfunction

    function void flip_top(int unsigned k);
        int unsigned lo;
        int unsigned hi;
        t_dist       t;
        lo = depth - k;
        hi = depth;
        while (lo + 1 < hi) begin
            t             = dists[lo];
            dists[lo]     = dists[hi - 1];
            dists[hi - 1] = t;
            lo++;
            hi--;
        end
    endfunction

    // follow the chain on top, or skip it when it lies past the limit
    function void enter_next_chain();
        if (dists[depth - 1] > limit) begin
            mode = MODE_SKIP_CHAIN;
            void'(push_zero());
        end else begin
            mode = MODE_SCAN_CHAIN;
        end
    endfunction

    // apply one accepted token; return 0 when the scanner ignores it as halted
    function bit take_token(bit first, logic [2:0] kind, t_val value);
        int unsigned d;
        t_dist       p;
        t_dist       c;
        t_dist       k;
        t_val        seed;
        scan_word_t  w;
        emit = 1'b0;
        code = ST_SEED;
        seed = '0;
        if (first) begin
            mode   = MODE_START;
            depth  = 0;
            halted = 1'b0;
        end
        if (halted) return 1'b0;
        d = depth;
        case (mode)
            MODE_START: begin
                if (kind == K_SEED) begin
                    if (push_zero()) mode = MODE_SCAN_CHAIN;
                end else begin
                    raise(ST_ERROR);
                end
            end
            MODE_SCAN_CHAIN: begin
                case (kind)
                    K_SEED: begin
                        if (d < 1) begin
                            raise(ST_ERROR);
                        end else begin
                            raise(ST_SEED);
                            seed = value;
                        end
                    end
                    K_SNARL_END: begin
                        if (push_zero()) mode = MODE_STACK_SNARL;
                    end
                    K_CHAIN_START: begin
                        if (d == 1) begin
                            if (push_zero()) mode = MODE_STACK_SNARL;
                        end else if (d == 0) begin
                            raise(ST_ERROR);
                        end else begin
                            depth--;
                            mode = MODE_SCAN_SNARL;
                        end
                    end
                    K_EDGE: begin
                        if (d < 1) begin
                            raise(ST_ERROR);
                        end else begin
                            dists[d - 1] = add_sat(dists[d - 1], value);
                            if (dists[d - 1] > limit) begin
                                if (d == 1) begin
                                    raise(ST_HALT);
                                end else begin
                                    void'(push_zero());
                                    mode = MODE_SKIP_CHAIN;
                                end
                            end
                        end
                    end
                    default: raise(ST_ERROR);
                endcase
            end
            MODE_STACK_SNARL: begin
                if (kind == K_EDGE) begin
                    if (d < 2) begin
                        raise(ST_ERROR);
                    end else if (d >= STACK_DEPTH) begin
                        raise(ST_OVERFLOW);
                    end else begin
                        p            = dists[d - 2];
                        c            = dists[d - 1];
                        dists[d - 2] = add_sat(p, value);
                        dists[d - 1] = p;
                        dists[d]     = c + 1'b1;
                        depth        = d + 1;
                    end
                end else if (kind == K_CHAIN_END) begin
                    k = (d >= 2) ? dists[d - 1] : '0;
                    if (d < 3 || k > t_dist'(d - 2)) begin
                        raise(ST_ERROR);
                    end else begin
                        depth = d - 2;
                        flip_top(k);
                        enter_next_chain();
                    end
                end else begin
                    raise(ST_ERROR);
                end
            end
            MODE_SCAN_SNARL: begin
                if (kind == K_SNARL_START) begin
                    mode = MODE_SCAN_CHAIN;
                end else if (kind == K_CHAIN_END) begin
                    if (d < 1) raise(ST_ERROR);
                    else enter_next_chain();
                end else if (kind != K_EDGE) begin
                    raise(ST_ERROR);
                end
            end
            MODE_SKIP_CHAIN: begin
                case (kind)
                    K_SEED, K_CHAIN_END, K_EDGE: ;
                    K_SNARL_START, K_SNARL_END, K_CHAIN_START: begin
                        if (d < 1) begin
                            raise(ST_ERROR);
                        end else if (kind == K_SNARL_START) begin
                            dists[d - 1] = dists[d - 1] - 1'b1;
                        end else if (kind == K_SNARL_END) begin
                            dists[d - 1] = dists[d - 1] + 1'b1;
                        end else if (dists[d - 1] == '0) begin
                            if (d < 3) begin
                                raise(ST_ERROR);
                            end else begin
                                depth = d - 2;
                                mode  = MODE_SCAN_SNARL;
                            end
                        end
                    end
                    default: raise(ST_ERROR);
                endcase
            end
            default: raise(ST_ERROR);
        endcase
        if (!emit) return 1'b1;
        if (code != ST_SEED) halted = 1'b1;
        w.status   = code;
        w.seed     = seed;
        w.dist_val = (depth != 0) ? dists[depth - 1] : '0;
        pending_words.push_back(w);
        return 1'b1;
    endfunction

    function void match_word(logic [1:0] status, t_val seed, t_dist act_dist);
        scan_word_t w;
        if (pending_words.size() == 0) begin
            $display("%0t: unexpected result word, status %0d seed %0h distance %0h",
                     $time, status, seed, act_dist);
            mismatches++;
            return;
        end
        w = pending_words.pop_front();
        if (status !== w.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time, w.status, status);
            mismatches++;
        end
        if (seed !== w.seed) begin
            $display("%0t: seed index mismatch, expected %0h actual %0h", $time, w.seed, seed);
            mismatches++;
        end
        if (act_dist !== w.dist_val) begin
            $display("%0t: distance mismatch, expected %0h actual %0h", $time, w.dist_val,
                     act_dist);
            mismatches++;
        end
    endfunction
endclass

module tb_nested_tree_distance_scanner;

    localparam int WATCHDOG_CYCLES = 4000;
    // longest token is a chain end reversing a full stack
    localparam int SETTLE_CYCLES   = 200;
    localparam int PHASE_WORDS     = 155;
    localparam int PHASES          = 7;

    // kinds the scanner never accepts in any mode
    localparam logic [2:0] K_SPARE_6 = 3'd6;
    localparam logic [2:0] K_SPARE_7 = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_distance_limit_we;
    logic [31:0] i_distance_limit;
    logic        i_valid;
    logic        o_ready;
    logic        i_first;
    logic [2:0]  i_kind;
    logic [31:0] i_token_value;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_seed_index;
    logic [31:0] o_distance;

    tree_scan_model scan_model;
    bit             gaps_on     = 1'b1;
    int unsigned    live_words  = 0;
    int unsigned    fan_target  = 1;
    int unsigned    idle_cycles = 0;

    nested_tree_distance_scanner uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_distance_limit_we (i_distance_limit_we),
        .i_distance_limit    (i_distance_limit),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_first             (i_first),
        .i_kind              (i_kind),
        .i_token_value       (i_token_value),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_seed_index        (o_seed_index),
        .o_distance          (o_distance)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side now and then; hold ready high while gaps are off.
    always @(negedge i_clk) begin
        i_ready <= !gaps_on || ($urandom_range(99) >= 19);
    end

    // Sample both handshakes at the rising edge. Check the result word first:
    // it always belongs to a token accepted on an earlier edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                scan_model.match_word(o_status, o_seed_index, o_distance);
            end
            if (i_valid && o_ready) begin
                if (scan_model.take_token(i_first, i_kind, i_token_value)) live_words++;
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long.
    initial begin
        while (idle_cycles < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Present one token word and hold it until accepted. Enter and leave just
    // after a falling edge, so the next word can follow back to back.
    task automatic drive_word(input bit first, input logic [2:0] kind, input t_val value);
        while (gaps_on && $urandom_range(99) < 19) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_first       = first;
        i_kind        = kind;
        i_token_value = value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drain every pending result, let the block settle, then load a new limit.
    task automatic set_limit(input t_dist value);
        i_valid = 1'b0;
        while (scan_model.pending_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_distance_limit_we = 1'b1;
        i_distance_limit    = value;
        @(negedge i_clk);
        i_distance_limit_we = 1'b0;
        scan_model.limit    = value;
    endtask

    // Mostly short edges, some landing on or just past the limit, a few huge.
    function automatic t_val edge_length(input t_dist base);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 70) return $urandom_range(60);
        if (r < 82) return scan_model.limit - base + $urandom_range(1);
        if (r < 94) return $urandom;
        return '1;
    endfunction

    // Number of child chains for the next snarl; rarely enough to overflow.
    function automatic int unsigned pick_fanout();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 30);
        return STACK_DEPTH + 6;
    endfunction

    // Choose the next token from the current scanner mode so that most words
    // form a well-shaped backward walk; mix in restarts and random noise.
    function automatic void pick_token(output bit first, output logic [2:0] kind,
                                       output t_val value);
        int unsigned r;
        int unsigned lane;
        t_dist       top;
        t_dist       base;
        r     = $urandom_range(99);
        lane  = $urandom_range(99);
        top   = (scan_model.depth != 0) ? scan_model.dists[scan_model.depth - 1] : '0;
        base  = (scan_model.depth >= 2) ? scan_model.dists[scan_model.depth - 2] : '0;
        first = 1'b0;
        kind  = K_SEED;
        value = $urandom;
        if ((scan_model.halted && r < 85) || r < 2) begin
            first = 1'b1;
        end else if (r >= 92) begin
            first = ($urandom_range(9) == 0);
            kind  = 3'($urandom_range(7));
        end else begin
            case (scan_model.mode)
                MODE_SCAN_CHAIN: begin
                    if (lane < 30) begin
                        kind = K_SEED;
                    end else if (lane < 65) begin
                        kind  = K_EDGE;
                        value = edge_length(top);
                    end else begin
                        kind       = (lane < 82) ? K_SNARL_END : K_CHAIN_START;
                        fan_target = pick_fanout();
                    end
                end
                MODE_STACK_SNARL: begin
                    // top of stack counts the edges seen so far in this snarl
                    if (top < fan_target) begin
                        kind  = K_EDGE;
                        value = edge_length(base);
                    end else begin
                        kind = K_CHAIN_END;
                    end
                end
                MODE_SCAN_SNARL: begin
                    if (lane < 50) kind = K_CHAIN_END;
                    else if (lane < 85) kind = K_SNARL_START;
                    else kind = K_EDGE;
                end
                MODE_SKIP_CHAIN: begin
                    // top of stack is the nesting level inside the skipped chain
                    if (lane < 40) begin
                        kind = (top == '0) ? K_CHAIN_START : K_SNARL_START;
                    end else if (lane < 55) begin
                        kind = K_SNARL_END;
                    end else begin
                        case ($urandom_range(2))
                            0:       kind = K_SEED;
                            1:       kind = K_CHAIN_END;
                            default: kind = K_EDGE;
                        endcase
                    end
                end
                default: kind = K_SEED;
            endcase
        end
    endfunction

    initial begin
        bit          first;
        logic [2:0]  kind;
        t_val        value;
        int unsigned target;

        scan_model          = new();
        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_first             = 1'b0;
        i_kind              = K_SEED;
        i_token_value       = '0;
        i_distance_limit_we = 1'b0;
        i_distance_limit    = '1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed walk under the reset limit: saturation and error paths.
        drive_word(1'b1, K_SEED, '1);              // start seed opens the scan only
        drive_word(1'b0, K_SEED, '1);              // yield at distance zero
        drive_word(1'b0, K_EDGE, '1);              // saturate the running distance
        drive_word(1'b0, K_SEED, '0);              // yield at the saturated distance
        drive_word(1'b0, K_SNARL_END, '0);
        drive_word(1'b0, K_EDGE, 32'd3);
        drive_word(1'b0, K_CHAIN_END, '0);         // single child chain, follow it
        drive_word(1'b0, K_SPARE_6, '0);           // unknown kind, scanner halts
        drive_word(1'b0, K_SEED, 32'h1);           // dropped while halted
        drive_word(1'b1, K_SPARE_7, '0);           // unknown kind in start mode
        drive_word(1'b1, K_SEED, 32'h8000_0000);
        drive_word(1'b0, K_SNARL_END, '0);
        drive_word(1'b0, K_CHAIN_END, '0);         // snarl with no edges
        drive_word(1'b1, K_EDGE, 32'd5);           // edge before any start seed

        // Directed walk under a small limit: skip, level wrap and halt.
        set_limit(32'd100);
        drive_word(1'b1, K_SEED, 32'd1);
        drive_word(1'b0, K_SNARL_END, '0);
        drive_word(1'b0, K_EDGE, 32'd200);         // far child lies past the limit
        drive_word(1'b0, K_EDGE, '0);
        drive_word(1'b0, K_CHAIN_END, '0);         // reorder, then skip the far chain
        drive_word(1'b0, K_SNARL_START, '0);       // nesting level wraps below zero
        drive_word(1'b0, K_SNARL_END, '0);
        drive_word(1'b0, K_CHAIN_START, '0);       // leave the skipped chain
        drive_word(1'b0, K_CHAIN_END, '0);         // enter the near chain
        drive_word(1'b0, K_SEED, 32'h5A5A_A5A5);
        drive_word(1'b0, K_EDGE, 32'd101);         // outermost chain passes the limit
        drive_word(1'b1, K_SEED, '0);
        drive_word(1'b0, K_EDGE, 32'd100);         // exactly at the limit, keep going
        drive_word(1'b0, K_SEED, 32'd7);

        // Random walks, one limit per phase; run one phase with no gaps at all.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       set_limit('1);
                1:       set_limit('0);
                2:       set_limit(32'd40);
                3:       set_limit(32'd300);
                4:       set_limit($urandom);
                5:       set_limit(32'd2000);
                default: set_limit(32'd12);
            endcase
            gaps_on = (ph != 2);
            target  = live_words + PHASE_WORDS;
            while (live_words < target) begin
                pick_token(first, kind, value);
                drive_word(first, kind, value);
            end
        end
        gaps_on = 1'b1;

        // Drop valid, drain, and give the block time for a stray late word.
        i_valid = 1'b0;
        while (scan_model.pending_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (scan_model.mismatches == 0 && scan_model.pending_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/ntds_pkg.sv
design/ntds_ram.sv
design/nested_tree_distance_scanner.sv
test/tb_nested_tree_distance_scanner.sv
